/* hw/rtl/mdm_pkg.sv */
// Shared widths, constants, register codes and pipeline types of the mecanum drive mixer.
`timescale 1ns / 1ps

package mdm_pkg;

    // Wheel output scaling
    localparam int OUTPUT_SCALE = 4095;
    localparam int WHEEL_LIMIT  = 4095;
    localparam int WHEEL_W      = 13;

    // Field widths
    localparam int TRIG_W  = 15;
    localparam int AXIS_W  = 16;
    localparam int KEY_W   = 6;
    localparam int SPEED_W = 12;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    // Q.16 fixed point: mapped axis, key step, motion components, magnitudes
    localparam int MAP_W  = 18;
    localparam int STEP_W = 17;
    localparam int COMP_W = 20;
    localparam int MAG_W  = 19;

    localparam int Q_ONE    = 65536;
    localparam int Q_TENTH  = 6554;
    localparam int DEADZONE = 3277;

    // Axis mapping by reciprocal: floor(a*294912/163835) and floor(9*a/5)
    localparam int MAP_SHIFT = 33;
    localparam int RECIP_W   = 34;
    localparam logic [RECIP_W-1:0] MAP_POS_RECIP =
        RECIP_W'(((64'd9 << 48) + 64'd163834) / 64'd163835);
    localparam logic [RECIP_W-1:0] MAP_NEG_RECIP =
        RECIP_W'(((64'd9 << MAP_SHIFT) + 64'd4) / 64'd5);

    // Key step by reciprocal: floor(speed*65536/4095)
    localparam int STEP_SHIFT   = 26;
    localparam int STEP_RECIP_W = 31;
    localparam logic [STEP_RECIP_W-1:0] STEP_RECIP =
        STEP_RECIP_W'(((64'd1 << 42) + 64'd4094) / 64'd4095);

    // Wheel divider
    localparam int QUO_W   = $clog2(OUTPUT_SCALE + 1);
    localparam int PROD_W  = MAG_W + QUO_W;
    localparam int CMP_W   = (QUO_W > WHEEL_W) ? QUO_W : WHEEL_W;
    localparam int DIV_LAT = QUO_W + 2;

    // Key mask bits
    localparam int KEY_FWD     = 0;
    localparam int KEY_LEFT    = 1;
    localparam int KEY_BACK    = 2;
    localparam int KEY_RIGHT   = 3;
    localparam int KEY_ROT_NEG = 4;
    localparam int KEY_ROT_POS = 5;

    typedef enum logic [1:0] {
        REG_DRIVE_ENABLE    = 2'd0,
        REG_KEYBOARD_ENABLE = 2'd1,
        REG_GAMEPAD_ENABLE  = 2'd2,
        REG_KEYBOARD_SPEED  = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [MAG_W-1:0] rem;
        logic [QUO_W-1:0] low;
        logic [QUO_W-1:0] quo;
        logic [MAG_W-1:0] den;
        logic             neg;
    } div_stage_t;

endpackage

/* hw/rtl/mdm_axis_map.sv */
// Two-stage axis normalizer: deadzone, reciprocal scaling and 0.1 offset.
`timescale 1ns / 1ps

module mdm_axis_map (
    input  logic                              clk,
    input  logic signed [mdm_pkg::AXIS_W-1:0] axis,
    output logic signed [mdm_pkg::MAP_W-1:0]  mapped
);

    logic                                            neg;
    logic                                            live;
    logic [mdm_pkg::AXIS_W-1:0]                      mag;
    logic [mdm_pkg::RECIP_W-1:0]                     recip;
    logic [mdm_pkg::AXIS_W+mdm_pkg::RECIP_W-1:0]     prod;

    logic [mdm_pkg::AXIS_W-1:0]                      quo_reg;
    logic                                            neg_reg;
    logic                                            live_reg;
    logic signed [mdm_pkg::MAP_W-1:0]                mapped_next;
    logic signed [mdm_pkg::MAP_W-1:0]                mapped_reg;

    always_comb
    begin
        neg   = axis[mdm_pkg::AXIS_W-1];
        mag   = neg ? mdm_pkg::AXIS_W'(-axis) : mdm_pkg::AXIS_W'(axis);
        live  = (mag >= mdm_pkg::AXIS_W'(mdm_pkg::DEADZONE));
        recip = neg ? mdm_pkg::MAP_NEG_RECIP : mdm_pkg::MAP_POS_RECIP;
        prod  = (mdm_pkg::AXIS_W + mdm_pkg::RECIP_W)'(mag)
              * (mdm_pkg::AXIS_W + mdm_pkg::RECIP_W)'(recip);
    end

    always_ff @(posedge clk)
    begin
        quo_reg  <= prod[mdm_pkg::MAP_SHIFT +: mdm_pkg::AXIS_W];
        neg_reg  <= neg;
        live_reg <= live;
    end

    // Add the tenth offset on both sides of zero
    always_comb
    begin
        if (!live_reg)
        begin
            mapped_next = '0;
        end
        else if (neg_reg)
        begin
            mapped_next = mdm_pkg::MAP_W'(mdm_pkg::Q_TENTH) - mdm_pkg::MAP_W'(quo_reg);
        end
        else
        begin
            mapped_next = mdm_pkg::MAP_W'(quo_reg) + mdm_pkg::MAP_W'(mdm_pkg::Q_TENTH);
        end
    end

    always_ff @(posedge clk)
    begin
        mapped_reg <= mapped_next;
    end

    assign mapped = mapped_reg;

endmodule

/* hw/rtl/mdm_wheel_div.sv */
// Pipelined restoring divider: magnitude times scale over denominator, signed and clamped.
`timescale 1ns / 1ps

module mdm_wheel_div (
    input  logic                               clk,
    input  logic [mdm_pkg::MAG_W-1:0]          mag,
    input  logic [mdm_pkg::MAG_W-1:0]          den,
    input  logic                               neg,
    output logic signed [mdm_pkg::WHEEL_W-1:0] wheel
);

    logic [mdm_pkg::PROD_W-1:0]      prod;
    mdm_pkg::div_stage_t             stage_next [mdm_pkg::QUO_W+1];
    mdm_pkg::div_stage_t             stage_reg  [mdm_pkg::QUO_W+1];
    logic [mdm_pkg::MAG_W:0]         trial      [mdm_pkg::QUO_W];
    logic [mdm_pkg::MAG_W:0]         diff       [mdm_pkg::QUO_W];
    logic                            take       [mdm_pkg::QUO_W];
    logic [mdm_pkg::CMP_W-1:0]       quo_ext;
    logic [mdm_pkg::CMP_W-1:0]       quo_sat;
    logic signed [mdm_pkg::WHEEL_W-1:0] wheel_next;
    logic signed [mdm_pkg::WHEEL_W-1:0] wheel_reg;

    // The quotient never exceeds the scale, so the high part starts below den
    assign prod = mdm_pkg::PROD_W'(mag) * mdm_pkg::PROD_W'(mdm_pkg::OUTPUT_SCALE);

    always_comb
    begin
        stage_next[0].rem = prod[mdm_pkg::PROD_W-1:mdm_pkg::QUO_W];
        stage_next[0].low = prod[mdm_pkg::QUO_W-1:0];
        stage_next[0].quo = '0;
        stage_next[0].den = den;
        stage_next[0].neg = neg;
        for (int s = 0; s < mdm_pkg::QUO_W; s++)
        begin
            trial[s] = {stage_reg[s].rem, stage_reg[s].low[mdm_pkg::QUO_W-1]};
            diff[s]  = trial[s] - {1'b0, stage_reg[s].den};
            take[s]  = (trial[s] >= {1'b0, stage_reg[s].den});
            stage_next[s+1].rem = take[s] ? diff[s][mdm_pkg::MAG_W-1:0]
                                          : trial[s][mdm_pkg::MAG_W-1:0];
            stage_next[s+1].low = {stage_reg[s].low[mdm_pkg::QUO_W-2:0], 1'b0};
            stage_next[s+1].quo = {stage_reg[s].quo[mdm_pkg::QUO_W-2:0], take[s]};
            stage_next[s+1].den = stage_reg[s].den;
            stage_next[s+1].neg = stage_reg[s].neg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s <= mdm_pkg::QUO_W; s++)
        begin
            stage_reg[s] <= stage_next[s];
        end
    end

    // Clamp the magnitude, then restore the sign (truncation toward zero)
    always_comb
    begin
        quo_ext = mdm_pkg::CMP_W'(stage_reg[mdm_pkg::QUO_W].quo);
        quo_sat = (quo_ext > mdm_pkg::CMP_W'(mdm_pkg::WHEEL_LIMIT))
                ? mdm_pkg::CMP_W'(mdm_pkg::WHEEL_LIMIT) : quo_ext;
        wheel_next = stage_reg[mdm_pkg::QUO_W].neg ? -mdm_pkg::WHEEL_W'(quo_sat)
                                                   : mdm_pkg::WHEEL_W'(quo_sat);
    end

    always_ff @(posedge clk)
    begin
        wheel_reg <= wheel_next;
    end

    assign wheel = wheel_reg;

endmodule

/* hw/rtl/mecanum_drive_mixer.sv */
// Mecanum drive mixer top level: APB registers, axis mapping, mixing and wheel division.
// Each word passes the capture stage, stages A to E and the wheel dividers before done rises.
// Throughput: one word per cycle; busy stays low and every stage advances each cycle.
// Reset clears the registers to their defaults and empties the valid pipeline at once.
// done pulses for one cycle per result; the receiver cannot stall, so nothing backs up.
`timescale 1ns / 1ps

module mecanum_drive_mixer (
    input  logic                               clk,
    input  logic                               rst_n,
    // APB configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [mdm_pkg::ADDR_W-1:0]         paddr,
    input  logic [mdm_pkg::DATA_W-1:0]         pwdata,
    output logic [mdm_pkg::DATA_W-1:0]         prdata,
    output logic                               pready,
    // Command handshake
    input  logic                               start,
    output logic                               busy,
    input  logic                               link_up,
    input  logic                               gamepad_present,
    input  logic [mdm_pkg::TRIG_W-1:0]         right_trigger,
    input  logic [mdm_pkg::TRIG_W-1:0]         left_trigger,
    input  logic signed [mdm_pkg::AXIS_W-1:0]  right_stick_x,
    input  logic signed [mdm_pkg::AXIS_W-1:0]  left_stick_x,
    input  logic [mdm_pkg::KEY_W-1:0]          key_mask,
    // Result strobe and wheel commands
    output logic                               done,
    output logic signed [mdm_pkg::WHEEL_W-1:0] right_front,
    output logic signed [mdm_pkg::WHEEL_W-1:0] right_back,
    output logic signed [mdm_pkg::WHEEL_W-1:0] left_front,
    output logic signed [mdm_pkg::WHEEL_W-1:0] left_back
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic                          drive_enable_reg;
    logic                          keyboard_enable_reg;
    logic                          gamepad_enable_reg;
    logic [mdm_pkg::SPEED_W-1:0]   keyboard_speed_reg;
    logic                          cfg_write;
    mdm_pkg::reg_index_t           cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;
    assign cfg_index = mdm_pkg::reg_index_t'(paddr[mdm_pkg::ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_enable_reg    <= 1'b0;
            keyboard_enable_reg <= 1'b0;
            gamepad_enable_reg  <= 1'b1;
            keyboard_speed_reg  <= mdm_pkg::SPEED_W'(2048);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                mdm_pkg::REG_DRIVE_ENABLE:    drive_enable_reg    <= pwdata[0];
                mdm_pkg::REG_KEYBOARD_ENABLE: keyboard_enable_reg <= pwdata[0];
                mdm_pkg::REG_GAMEPAD_ENABLE:  gamepad_enable_reg  <= pwdata[0];
                mdm_pkg::REG_KEYBOARD_SPEED:  keyboard_speed_reg  <= pwdata[mdm_pkg::SPEED_W-1:0];
            endcase
        end
    end

    // Read data is combinational; APB samples it in the access cycle
    always_comb
    begin
        unique case (cfg_index)
            mdm_pkg::REG_DRIVE_ENABLE:    prdata = mdm_pkg::DATA_W'(drive_enable_reg);
            mdm_pkg::REG_KEYBOARD_ENABLE: prdata = mdm_pkg::DATA_W'(keyboard_enable_reg);
            mdm_pkg::REG_GAMEPAD_ENABLE:  prdata = mdm_pkg::DATA_W'(gamepad_enable_reg);
            mdm_pkg::REG_KEYBOARD_SPEED:  prdata = mdm_pkg::DATA_W'(keyboard_speed_reg);
        endcase
    end

    // ------------------------------------------------------------------
    // Capture stage
    // Every cycle may start a word. A word only becomes valid when drive is
    // enabled and the link is up; otherwise it is dropped right here and
    // produces no result. The enables are folded into the captured payload
    // so the later stages need not look at the enable registers again.
    // ------------------------------------------------------------------
    assign busy = 1'b0;

    logic                                v_c_reg;
    logic                                gp_c_reg;
    logic [mdm_pkg::KEY_W-1:0]           keys_c_reg;
    logic [mdm_pkg::TRIG_W-1:0]          rt_c_reg;
    logic [mdm_pkg::TRIG_W-1:0]          lt_c_reg;
    logic signed [mdm_pkg::AXIS_W-1:0]   rx_c_reg;
    logic signed [mdm_pkg::AXIS_W-1:0]   lx_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_c_reg <= 1'b0;
        end
        else
        begin
            v_c_reg <= start & drive_enable_reg & link_up;
        end
    end

    always_ff @(posedge clk)
    begin
        gp_c_reg   <= gamepad_enable_reg & gamepad_present;
        keys_c_reg <= keyboard_enable_reg ? key_mask : '0;
        rt_c_reg   <= right_trigger;
        lt_c_reg   <= left_trigger;
        rx_c_reg   <= right_stick_x;
        lx_c_reg   <= left_stick_x;
    end

    // ------------------------------------------------------------------
    // Stages A and B: axis mapping (two stages inside each mapper), with
    // the key step computed alongside and carried to line up with them.
    // ------------------------------------------------------------------
    logic signed [mdm_pkg::MAP_W-1:0] map_rt;
    logic signed [mdm_pkg::MAP_W-1:0] map_lt;
    logic signed [mdm_pkg::MAP_W-1:0] map_rx;
    logic signed [mdm_pkg::MAP_W-1:0] map_lx;

    mdm_axis_map u_map_rt (
        .clk    (clk),
        .axis   (signed'({1'b0, rt_c_reg})),
        .mapped (map_rt)
    );

    mdm_axis_map u_map_lt (
        .clk    (clk),
        .axis   (signed'({1'b0, lt_c_reg})),
        .mapped (map_lt)
    );

    mdm_axis_map u_map_rx (
        .clk    (clk),
        .axis   (rx_c_reg),
        .mapped (map_rx)
    );

    mdm_axis_map u_map_lx (
        .clk    (clk),
        .axis   (lx_c_reg),
        .mapped (map_lx)
    );

    // Key step: speed/4095 in Q.16, by reciprocal multiply (exact over 12 bits)
    logic [mdm_pkg::SPEED_W+mdm_pkg::STEP_RECIP_W-1:0] step_prod;
    logic [mdm_pkg::STEP_W-1:0]                        step_next;

    assign step_prod = (mdm_pkg::SPEED_W + mdm_pkg::STEP_RECIP_W)'(keyboard_speed_reg)
                     * (mdm_pkg::SPEED_W + mdm_pkg::STEP_RECIP_W)'(mdm_pkg::STEP_RECIP);
    assign step_next = step_prod[mdm_pkg::STEP_SHIFT +: mdm_pkg::STEP_W];

    logic                        v_a_reg;
    logic                        v_b_reg;
    logic                        gp_a_reg;
    logic                        gp_b_reg;
    logic [mdm_pkg::KEY_W-1:0]   keys_a_reg;
    logic [mdm_pkg::KEY_W-1:0]   keys_b_reg;
    logic [mdm_pkg::STEP_W-1:0]  step_a_reg;
    logic [mdm_pkg::STEP_W-1:0]  step_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_a_reg <= 1'b0;
            v_b_reg <= 1'b0;
        end
        else
        begin
            v_a_reg <= v_c_reg;
            v_b_reg <= v_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        gp_a_reg   <= gp_c_reg;
        gp_b_reg   <= gp_a_reg;
        keys_a_reg <= keys_c_reg;
        keys_b_reg <= keys_a_reg;
        step_a_reg <= step_next;
        step_b_reg <= step_a_reg;
    end

    // ------------------------------------------------------------------
    // Stage C: motion components (forward, strafe right, rotate)
    // Gamepad axes contribute only when enabled and present; keys add or
    // subtract the step. All components stay within +-3.0 in Q.16.
    // ------------------------------------------------------------------
    logic signed [mdm_pkg::COMP_W-1:0] step_s;
    logic signed [mdm_pkg::COMP_W-1:0] rt_x;
    logic signed [mdm_pkg::COMP_W-1:0] lt_x;
    logic signed [mdm_pkg::COMP_W-1:0] rx_x;
    logic signed [mdm_pkg::COMP_W-1:0] lx_x;
    logic signed [mdm_pkg::COMP_W-1:0] fwd_next;
    logic signed [mdm_pkg::COMP_W-1:0] right_next;
    logic signed [mdm_pkg::COMP_W-1:0] rot_next;
    logic signed [mdm_pkg::COMP_W-1:0] fwd_reg;
    logic signed [mdm_pkg::COMP_W-1:0] right_reg;
    logic signed [mdm_pkg::COMP_W-1:0] rot_reg;
    logic                              v_mix_reg;

    always_comb
    begin
        step_s = signed'(mdm_pkg::COMP_W'(step_b_reg));
        rt_x   = gp_b_reg ? mdm_pkg::COMP_W'(map_rt) : '0;
        lt_x   = gp_b_reg ? mdm_pkg::COMP_W'(map_lt) : '0;
        rx_x   = gp_b_reg ? mdm_pkg::COMP_W'(map_rx) : '0;
        lx_x   = gp_b_reg ? mdm_pkg::COMP_W'(map_lx) : '0;

        fwd_next   = rt_x - lt_x
                   + (keys_b_reg[mdm_pkg::KEY_FWD]     ? step_s : '0)
                   - (keys_b_reg[mdm_pkg::KEY_BACK]    ? step_s : '0);
        right_next = rx_x
                   - (keys_b_reg[mdm_pkg::KEY_LEFT]    ? step_s : '0)
                   + (keys_b_reg[mdm_pkg::KEY_RIGHT]   ? step_s : '0);
        rot_next   = lx_x
                   - (keys_b_reg[mdm_pkg::KEY_ROT_NEG] ? step_s : '0)
                   + (keys_b_reg[mdm_pkg::KEY_ROT_POS] ? step_s : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_mix_reg <= 1'b0;
        end
        else
        begin
            v_mix_reg <= v_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_reg   <= fwd_next;
        right_reg <= right_next;
        rot_reg   <= rot_next;
    end

    // ------------------------------------------------------------------
    // Stage D: wheel numerators and component magnitudes
    // Wheel order: right front, right back, left front, left back.
    // ------------------------------------------------------------------
    logic signed [mdm_pkg::COMP_W-1:0] num_next   [4];
    logic signed [mdm_pkg::COMP_W-1:0] num_d_reg  [4];
    logic [mdm_pkg::MAG_W-1:0]         abs_next   [3];
    logic [mdm_pkg::MAG_W-1:0]         abs_d_reg  [3];
    logic                              v_d_reg;

    always_comb
    begin
        num_next[0] = fwd_reg - right_reg - rot_reg;
        num_next[1] = fwd_reg + right_reg - rot_reg;
        num_next[2] = fwd_reg + right_reg + rot_reg;
        num_next[3] = fwd_reg - right_reg + rot_reg;
        abs_next[0] = fwd_reg[mdm_pkg::COMP_W-1]
                    ? mdm_pkg::MAG_W'(-fwd_reg) : mdm_pkg::MAG_W'(fwd_reg);
        abs_next[1] = right_reg[mdm_pkg::COMP_W-1]
                    ? mdm_pkg::MAG_W'(-right_reg) : mdm_pkg::MAG_W'(right_reg);
        abs_next[2] = rot_reg[mdm_pkg::COMP_W-1]
                    ? mdm_pkg::MAG_W'(-rot_reg) : mdm_pkg::MAG_W'(rot_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_d_reg <= 1'b0;
        end
        else
        begin
            v_d_reg <= v_mix_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            num_d_reg[i] <= num_next[i];
        end
        for (int i = 0; i < 3; i++)
        begin
            abs_d_reg[i] <= abs_next[i];
        end
    end

    // ------------------------------------------------------------------
    // Stage E: denominator max(sum of magnitudes, 1.0), numerator sign and
    // magnitude. Each numerator is bounded by the sum, so every quotient
    // stays within the output scale.
    // ------------------------------------------------------------------
    logic [mdm_pkg::MAG_W+1:0]  den_sum;
    logic [mdm_pkg::MAG_W-1:0]  den_next;
    logic [mdm_pkg::MAG_W-1:0]  den_e_reg;
    logic [mdm_pkg::MAG_W-1:0]  mag_next   [4];
    logic [mdm_pkg::MAG_W-1:0]  mag_e_reg  [4];
    logic                       neg_next   [4];
    logic                       neg_e_reg  [4];
    logic                       v_e_reg;

    always_comb
    begin
        den_sum  = (mdm_pkg::MAG_W + 2)'(abs_d_reg[0])
                 + (mdm_pkg::MAG_W + 2)'(abs_d_reg[1])
                 + (mdm_pkg::MAG_W + 2)'(abs_d_reg[2]);
        den_next = (den_sum < (mdm_pkg::MAG_W + 2)'(mdm_pkg::Q_ONE))
                 ? mdm_pkg::MAG_W'(mdm_pkg::Q_ONE) : den_sum[mdm_pkg::MAG_W-1:0];
        for (int i = 0; i < 4; i++)
        begin
            neg_next[i] = num_d_reg[i][mdm_pkg::COMP_W-1];
            mag_next[i] = neg_next[i] ? mdm_pkg::MAG_W'(-num_d_reg[i])
                                      : mdm_pkg::MAG_W'(num_d_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_e_reg <= 1'b0;
        end
        else
        begin
            v_e_reg <= v_d_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        den_e_reg <= den_next;
        for (int i = 0; i < 4; i++)
        begin
            mag_e_reg[i] <= mag_next[i];
            neg_e_reg[i] <= neg_next[i];
        end
    end

    // ------------------------------------------------------------------
    // Wheel dividers: scale multiply, one quotient bit per stage, then
    // sign and clamp. The valid bit rides a matching shift line.
    // ------------------------------------------------------------------
    logic [mdm_pkg::DIV_LAT-1:0] div_valid_reg;
    logic [mdm_pkg::DIV_LAT-1:0] div_valid_next;

    assign div_valid_next = {div_valid_reg[mdm_pkg::DIV_LAT-2:0], v_e_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_valid_reg <= '0;
        end
        else
        begin
            div_valid_reg <= div_valid_next;
        end
    end

    // Strobe the word out for exactly one cycle
    assign done = div_valid_reg[mdm_pkg::DIV_LAT-1];

    mdm_wheel_div u_div_rf (
        .clk   (clk),
        .mag   (mag_e_reg[0]),
        .den   (den_e_reg),
        .neg   (neg_e_reg[0]),
        .wheel (right_front)
    );

    mdm_wheel_div u_div_rb (
        .clk   (clk),
        .mag   (mag_e_reg[1]),
        .den   (den_e_reg),
        .neg   (neg_e_reg[1]),
        .wheel (right_back)
    );

    mdm_wheel_div u_div_lf (
        .clk   (clk),
        .mag   (mag_e_reg[2]),
        .den   (den_e_reg),
        .neg   (neg_e_reg[2]),
        .wheel (left_front)
    );

    mdm_wheel_div u_div_lb (
        .clk   (clk),
        .mag   (mag_e_reg[3]),
        .den   (den_e_reg),
        .neg   (neg_e_reg[3]),
        .wheel (left_back)
    );

endmodule
